[rtl/core/fcpi_pkg.sv]
package fcpi_pkg;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    // program addresses
    localparam t_step S_WAIT  = 3'd0;
    localparam t_step S_FOLD  = 3'd1;
    localparam t_step S_ERR   = 3'd2;
    localparam t_step S_FILT  = 3'd3;
    localparam t_step S_INTEG = 3'd4;
    localparam t_step S_KI    = 3'd5;
    localparam t_step S_OUT   = 3'd6;

    localparam int GAIN_W  = 16;
    localparam int FILT_W  = 26;
    localparam int INTEG_W = 20;
    localparam int ERR_W   = 17;
    localparam int PROD_W  = FILT_W + GAIN_W;

    localparam logic signed [GAIN_W-1:0] C_FILT_OLD = 16'sd179;
    localparam logic signed [GAIN_W-1:0] C_FILT_NEW = 16'sd77;
    localparam logic signed [INTEG_W+6:0] INTEG_LIM = 27'sd384000;

    typedef enum logic [1:0] {A_FOLD, A_ERR, A_FILT, A_INTEG} t_asel;
    typedef enum logic [1:0] {B_OLD, B_NEW, B_KP, B_KI} t_bsel;
    typedef enum logic [2:0] {
        ACC_NONE, ACC_SHIFT, ACC_FILT, ACC_INTEG, ACC_LOAD, ACC_OUT
    } t_accop;
    typedef enum logic [1:0] {J_NEXT, J_WAIT_IN, J_BADCH, J_OUT_FREE} t_jmp;

    typedef struct packed {
        t_asel  a_sel;
        t_bsel  b_sel;
        logic   mul_en;
        t_accop acc_op;
        t_jmp   jmp;
        t_step  target;
    } t_ucw;

    function automatic t_ucw ucode(input t_step step);
        t_ucw w;
        w = '{a_sel: A_FOLD, b_sel: B_OLD, mul_en: 1'b0, acc_op: ACC_NONE,
              jmp: J_WAIT_IN, target: S_FOLD};
        case (step)
            S_WAIT: begin
                w.jmp    = J_WAIT_IN;
                w.target = S_FOLD;
            end
            S_FOLD: begin
                // 179 * old filter state; unknown channel skips to output
                w.a_sel  = A_FOLD;
                w.b_sel  = B_OLD;
                w.mul_en = 1'b1;
                w.jmp    = J_BADCH;
                w.target = S_OUT;
            end
            S_ERR: begin
                w.a_sel  = A_ERR;
                w.b_sel  = B_NEW;
                w.mul_en = 1'b1;
                w.acc_op = ACC_SHIFT;
                w.jmp    = J_NEXT;
            end
            S_FILT: begin
                w.acc_op = ACC_FILT;
                w.jmp    = J_NEXT;
            end
            S_INTEG: begin
                w.a_sel  = A_FILT;
                w.b_sel  = B_KP;
                w.mul_en = 1'b1;
                w.acc_op = ACC_INTEG;
                w.jmp    = J_NEXT;
            end
            S_KI: begin
                w.a_sel  = A_INTEG;
                w.b_sel  = B_KI;
                w.mul_en = 1'b1;
                w.acc_op = ACC_LOAD;
                w.jmp    = J_NEXT;
            end
            S_OUT: begin
                w.acc_op = ACC_OUT;
                w.jmp    = J_OUT_FREE;
                w.target = S_WAIT;
            end
            default: begin
                w.jmp    = J_OUT_FREE;
                w.target = S_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/core/four_channel_filtered_pi_speed_loop.sv]
// Channel  | Direction | Payload
// ---------+-----------+--------------------------------------------------
// s_axis   | in        | tuser: channel; tdata: measured_speed, target_speed
// m_axis   | out       | tuser: out_channel; tdata: drive
// cfg      | in        | i_cfg_addr selects Kp/Ki per channel, i_cfg_wdata Q8.8
//
// A short microprogram drives one shared 26x16 signed multiplier, four
// products per item. An item steps from wait through fold, error, filter,
// integrate, Ki and output back to wait; an item for a channel with no
// loop goes from fold straight to output. Synchronous active-low reset
// clears gains, filter state and integrals. The output register holds a
// result until taken; the last step waits there, and input is taken again
// as soon as the program is back at its wait step, even while a result waits.
module four_channel_filtered_pi_speed_loop
    import fcpi_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] measured_speed, [31:16] target_speed
    input  logic [1:0]  s_axis_tuser,   // [1:0] channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] drive
    output logic [1:0]  m_axis_tuser,   // [1:0] out_channel
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [GAIN_W-1:0]  r_kp [4];
    logic signed [GAIN_W-1:0]  r_ki [4];
    logic signed [FILT_W-1:0]  r_filt_st  [CHANNELS];
    logic signed [INTEG_W-1:0] r_integ_st [CHANNELS];

    t_step r_step, n_step;
    t_ucw  w_cw;

    logic [1:0]                r_ch;
    logic [IW-1:0]             r_idx;
    logic                      r_bad;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [FILT_W-1:0]  r_fold;
    logic signed [INTEG_W-1:0] r_iold;
    logic signed [FILT_W-1:0]  r_filt;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_acc;
    logic                      r_out_valid;
    logic [15:0]               r_drive;
    logic [1:0]                r_out_ch;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_in_bad;
    logic [IW-1:0]             w_in_idx;
    logic signed [FILT_W-1:0]  w_op_a;
    logic signed [GAIN_W-1:0]  w_op_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [INTEG_W+6:0] w_isum;
    logic signed [INTEG_W-1:0] w_iclamp;
    logic signed [PROD_W:0]    w_sum;
    logic signed [PROD_W+1:0]  w_rnd;
    logic signed [PROD_W-16:0] w_q;
    logic [15:0]               w_drive;

    assign w_cw          = ucode(r_step);
    assign s_axis_tready = (w_cw.jmp == J_WAIT_IN);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_in_bad      = ({3'b000, s_axis_tuser} >= 5'(CHANNELS));
    assign w_in_idx      = w_in_bad ? '0 : IW'(s_axis_tuser);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_drive;
    assign m_axis_tuser  = r_out_ch;

    // shared multiplier operands
    always_comb begin
        case (w_cw.a_sel)
            A_FOLD:  w_op_a = r_fold;
            A_ERR:   w_op_a = FILT_W'(r_err);
            A_FILT:  w_op_a = r_filt;
            A_INTEG: w_op_a = FILT_W'(r_integ);
            default: w_op_a = r_fold;
        endcase
        case (w_cw.b_sel)
            B_OLD:   w_op_b = C_FILT_OLD;
            B_NEW:   w_op_b = C_FILT_NEW;
            B_KP:    w_op_b = r_kp[r_ch];
            B_KI:    w_op_b = r_ki[r_ch];
            default: w_op_b = C_FILT_OLD;
        endcase
        w_prod = PROD_W'(w_op_a) * PROD_W'(w_op_b);
    end

    // integral clamp
    always_comb begin
        w_isum = (INTEG_W+7)'(r_iold) + (INTEG_W+7)'(r_filt);
        if (w_isum > INTEG_LIM) begin
            w_iclamp = INTEG_W'(INTEG_LIM);
        end else if (w_isum < -INTEG_LIM) begin
            w_iclamp = INTEG_W'(-INTEG_LIM);
        end else begin
            w_iclamp = INTEG_W'(w_isum);
        end
    end

    // Q.16 sum, truncate toward zero, saturate
    always_comb begin
        w_sum = (PROD_W+1)'(r_acc) + (PROD_W+1)'(r_prod);
        w_rnd = (PROD_W+2)'(w_sum) + (w_sum[PROD_W] ? (PROD_W+2)'(65535) : '0);
        w_q   = w_rnd[PROD_W:16];
        if (w_q > (PROD_W-15)'(32767)) begin
            w_drive = 16'h7fff;
        end else if (w_q < -(PROD_W-15)'(32768)) begin
            w_drive = 16'h8000;
        end else begin
            w_drive = w_q[15:0];
        end
    end

    always_comb begin
        n_step = r_step + t_step'(1);
        case (w_cw.jmp)
            J_NEXT:     n_step = r_step + t_step'(1);
            J_WAIT_IN:  n_step = w_in_acc ? w_cw.target : r_step;
            J_BADCH:    n_step = r_bad ? w_cw.target : r_step + t_step'(1);
            J_OUT_FREE: n_step = w_out_free ? w_cw.target : r_step;
            default:    n_step = S_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_WAIT;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_kp[i] <= '0;
                r_ki[i] <= '0;
            end
            for (int i = 0; i < CHANNELS; i++) begin
                r_filt_st[i]  <= '0;
                r_integ_st[i] <= '0;
            end
        end else begin
            r_step <= n_step;

            if (i_cfg_wr_en) begin
                if (i_cfg_addr[0]) begin
                    r_ki[i_cfg_addr[2:1]] <= i_cfg_wdata;
                end else begin
                    r_kp[i_cfg_addr[2:1]] <= i_cfg_wdata;
                end
            end

            if (w_cw.acc_op == ACC_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_in_acc) begin
                r_ch   <= s_axis_tuser;
                r_idx  <= w_in_idx;
                r_bad  <= w_in_bad;
                r_err  <= ERR_W'(signed'(s_axis_tdata[15:0]))
                        - ERR_W'(signed'(s_axis_tdata[31:16]));
                r_fold <= r_filt_st[w_in_idx];
                r_iold <= r_integ_st[w_in_idx];
            end

            if (w_cw.mul_en) begin
                r_prod <= w_prod;
            end

            case (w_cw.acc_op)
                ACC_SHIFT: r_acc  <= r_prod >>> 8;
                ACC_FILT:  r_filt <= FILT_W'(r_acc) + FILT_W'(r_prod);
                ACC_INTEG: begin
                    r_integ            <= w_iclamp;
                    r_filt_st[r_idx]   <= r_filt;
                    r_integ_st[r_idx]  <= w_iclamp;
                end
                ACC_LOAD:  r_acc  <= r_prod;
                ACC_OUT: begin
                    if (w_out_free) begin
                        r_out_ch    <= r_ch;
                        r_drive     <= r_bad ? '0 : w_drive;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
